[rtl/core/eth_ip_pkg.sv]
// eth_ip_pkg: field codes, protocol constants, record type and checksum adder
// shared by the header parser top level; no dependencies
package eth_ip_pkg;

	localparam int MaxFrameBytes = 1536;
	localparam int OffW = 11;
	localparam logic [OffW-1:0] MaxOff = OffW'(MaxFrameBytes);

	localparam logic [15:0] TypeIpv4 = 16'h0800;
	localparam logic [15:0] TypeArp = 16'h0806;
	localparam logic [7:0] ProtoIcmp = 8'h01;
	localparam logic [7:0] ProtoUdp = 8'h11;
	localparam logic [7:0] ProtoTcp = 8'h06;

	typedef enum logic [4:0] {
		F_DST_MAC = 5'd0, F_SRC_MAC = 5'd1, F_ETYPE = 5'd2, F_ARP_OP = 5'd3,
		F_ARP_SHA = 5'd4, F_ARP_SPA = 5'd5, F_ARP_THA = 5'd6, F_ARP_TPA = 5'd7,
		F_IP_VER = 5'd8, F_IP_HLEN = 5'd9, F_IP_DSCP = 5'd10, F_IP_ECN = 5'd11,
		F_IP_TTL = 5'd12, F_IP_PROTO = 5'd13, F_IP_CSUM = 5'd14, F_IP_OK = 5'd15,
		F_IP_SRC = 5'd16, F_IP_DST = 5'd17, F_ICMP_TYPE = 5'd18,
		F_UDP_SRC = 5'd19, F_UDP_DST = 5'd20, F_TCP_SRC = 5'd21, F_TCP_DST = 5'd22,
		F_TCP_SEQ = 5'd23, F_TCP_ACK = 5'd24, F_TCP_DOFF = 5'd25,
		F_TCP_FLAGS = 5'd26, F_TCP_WIN = 5'd27, F_TCP_CSUM = 5'd28,
		F_TCP_OK = 5'd29, F_END = 5'd30
	} field_id_t;

	typedef struct packed {
		field_id_t id;
		logic [47:0] value;
	} rec_t;

	function automatic logic [16:0] oc_add(input logic [16:0] s, input logic [15:0] w);
		logic [16:0] t;
		t = {1'b0, s[15:0]} + {1'b0, w};
		return {1'b0, t[15:0]} + 17'(t[16]);
	endfunction

endpackage

[rtl/core/eth_ip_header_parser.sv]
// eth_ip_header_parser: byte-wide ethernet/arp/ipv4/icmp/tcp/udp header parser
// records of a byte are presented in the cycle after it is taken, one per output
// handshake; a byte yields up to 4 records, and one with none produces no output
// throughput: one byte per cycle when each byte yields at most one record and the
// output is ready; a 4-entry buffer between parser and output sets the stall point
// reset: arst_n clears offset, sums, flags and record count; depends on eth_ip_pkg
module eth_ip_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        frame_end,
	input  logic        valid_in,
	output logic        ready_in,
	output logic [4:0]  field_id,
	output logic [47:0] field_value,
	output logic        last_of_run,
	output logic        valid_out,
	input  logic        ready_out
);
	import eth_ip_pkg::*;

	logic [OffW-1:0] off_q;
	logic [47:0] shift_q;
	logic [15:0] ftype_q, tlen_q, seglen_q;
	logic [3:0]  hw_q;
	logic [7:0]  proto_q;
	logic [16:0] ipsum_q, tcpsum_q;
	logic [1:0]  pend_q;

	rec_t        buf_q [4];
	logic [2:0]  cnt_q;
	logic [1:0]  rd_q;

	logic        take;
	rec_t        rec [4];
	logic [2:0]  n;

	logic [47:0] sh;
	logic [15:0] w16;
	logic [OffW-1:0] p, t;
	logic [15:0] hlen;
	logic [OffW-1:0] nxt_off;
	logic [47:0] nxt_shift;
	logic [15:0] nxt_ftype, nxt_tlen, nxt_seg;
	logic [3:0]  nxt_hw;
	logic [7:0]  nxt_proto;
	logic [16:0] nxt_ip, nxt_tcp;
	logic [1:0]  nxt_pend;
	logic [15:0] segc;
	logic        active;

	assign ready_in = (cnt_q == 3'd0) || (cnt_q == 3'd1 && ready_out);
	assign take = valid_in && ready_in;

	always_comb begin
		n = '0;
		for (int i = 0; i < 4; i++) begin
			rec[i] = '{id: F_END, value: '0};
		end
		nxt_off = off_q; nxt_shift = shift_q; nxt_ftype = ftype_q; nxt_tlen = tlen_q;
		nxt_seg = seglen_q; nxt_hw = hw_q; nxt_proto = proto_q; nxt_ip = ipsum_q;
		nxt_tcp = tcpsum_q; nxt_pend = pend_q;
		sh = {shift_q[39:0], data_byte};
		w16 = sh[15:0];
		p = off_q - OffW'(14);
		hlen = 16'd20;
		t = '0;
		segc = '0;
		active = off_q < MaxOff;
		if (active) begin
			nxt_off = off_q + 1'b1;
			nxt_shift = sh;
			if (off_q < OffW'(14)) begin
				if (off_q == OffW'(5)) begin rec[n[1:0]] = '{F_DST_MAC, sh}; n = n + 1'b1; end
				if (off_q == OffW'(11)) begin rec[n[1:0]] = '{F_SRC_MAC, sh}; n = n + 1'b1; end
				if (off_q == OffW'(13)) begin
					nxt_ftype = w16;
					rec[n[1:0]] = '{F_ETYPE, {32'd0, w16}}; n = n + 1'b1;
				end
			end else if (ftype_q == TypeArp) begin
				if (p == OffW'(7)) begin
					rec[n[1:0]] = '{F_ARP_OP, {32'd0, w16}}; n = n + 1'b1;
				end
				if (p == OffW'(13)) begin rec[n[1:0]] = '{F_ARP_SHA, sh}; n = n + 1'b1; end
				if (p == OffW'(17)) begin
					rec[n[1:0]] = '{F_ARP_SPA, {16'd0, sh[31:0]}}; n = n + 1'b1;
				end
				if (p == OffW'(23)) begin rec[n[1:0]] = '{F_ARP_THA, sh}; n = n + 1'b1; end
				if (p == OffW'(27)) begin
					rec[n[1:0]] = '{F_ARP_TPA, {16'd0, sh[31:0]}}; n = n + 1'b1;
				end
			end else if (ftype_q == TypeIpv4) begin
				if (p == '0) begin
					nxt_hw = data_byte[3:0];
					nxt_pend[0] = 1'b1;
					nxt_ip = '0; nxt_tcp = '0;
					rec[n[1:0]] = '{F_IP_VER, {44'd0, data_byte[7:4]}}; n = n + 1'b1;
					rec[n[1:0]] = '{F_IP_HLEN, {42'd0, data_byte[3:0], 2'b00}}; n = n + 1'b1;
				end
				hlen = (nxt_hw < 4'd5) ? 16'd20 : {10'd0, nxt_hw, 2'b00};
				if (p == OffW'(1)) begin
					rec[n[1:0]] = '{F_IP_DSCP, {42'd0, data_byte[7:2]}}; n = n + 1'b1;
					rec[n[1:0]] = '{F_IP_ECN, {46'd0, data_byte[1:0]}}; n = n + 1'b1;
				end
				if (p == OffW'(3)) nxt_tlen = w16;
				if (p == OffW'(8)) begin
					rec[n[1:0]] = '{F_IP_TTL, {40'd0, data_byte}}; n = n + 1'b1;
				end
				if (p == OffW'(9)) begin
					nxt_proto = data_byte;
					if (data_byte == ProtoTcp) nxt_pend[1] = 1'b1;
					rec[n[1:0]] = '{F_IP_PROTO, {40'd0, data_byte}}; n = n + 1'b1;
				end
				if (p == OffW'(11)) begin
					rec[n[1:0]] = '{F_IP_CSUM, {32'd0, w16}}; n = n + 1'b1;
				end
				if (p == OffW'(15)) begin
					rec[n[1:0]] = '{F_IP_SRC, {16'd0, sh[31:0]}}; n = n + 1'b1;
				end
				if (p == OffW'(19)) begin
					rec[n[1:0]] = '{F_IP_DST, {16'd0, sh[31:0]}}; n = n + 1'b1;
				end
				if ({5'd0, p} < hlen) begin
					if (p[0]) begin
						nxt_ip = oc_add(nxt_ip, w16);
						if (p >= OffW'(12) && p <= OffW'(19)) nxt_tcp = oc_add(nxt_tcp, w16);
					end
					if ({5'd0, p} == hlen - 16'd1) begin
						if (nxt_pend[0]) begin
							rec[n[1:0]] = '{F_IP_OK, {47'd0,
								(nxt_hw >= 4'd5 && nxt_ip[15:0] == 16'hFFFF
								 && !nxt_ip[16])}};
							n = n + 1'b1;
							nxt_pend[0] = 1'b0;
						end
						if (nxt_proto == ProtoTcp) begin
							segc = (nxt_tlen > hlen) ? nxt_tlen - hlen : 16'd0;
							nxt_seg = segc;
							nxt_tcp = oc_add(oc_add(nxt_tcp, {8'd0, ProtoTcp}), segc);
							if (segc == '0 && nxt_pend[1]) begin
								rec[n[1:0]] = '{F_TCP_OK, {47'd0, nxt_tcp == 17'h0FFFF}};
								n = n + 1'b1;
								nxt_pend[1] = 1'b0;
							end
						end
					end
				end else begin
					t = p - hlen[OffW-1:0];
					if (proto_q == ProtoIcmp) begin
						if (t == '0) begin
							rec[n[1:0]] = '{F_ICMP_TYPE, {40'd0, data_byte}}; n = n + 1'b1;
						end
					end else if (proto_q == ProtoUdp) begin
						if (t == OffW'(1)) begin
							rec[n[1:0]] = '{F_UDP_SRC, {32'd0, w16}}; n = n + 1'b1;
						end
						if (t == OffW'(3)) begin
							rec[n[1:0]] = '{F_UDP_DST, {32'd0, w16}}; n = n + 1'b1;
						end
					end else if (proto_q == ProtoTcp) begin
						if (t == OffW'(1)) begin
							rec[n[1:0]] = '{F_TCP_SRC, {32'd0, w16}}; n = n + 1'b1;
						end
						if (t == OffW'(3)) begin
							rec[n[1:0]] = '{F_TCP_DST, {32'd0, w16}}; n = n + 1'b1;
						end
						if (t == OffW'(7)) begin
							rec[n[1:0]] = '{F_TCP_SEQ, {16'd0, sh[31:0]}}; n = n + 1'b1;
						end
						if (t == OffW'(11)) begin
							rec[n[1:0]] = '{F_TCP_ACK, {16'd0, sh[31:0]}}; n = n + 1'b1;
						end
						if (t == OffW'(12)) begin
							rec[n[1:0]] = '{F_TCP_DOFF, {42'd0, data_byte[7:4], 2'b00}};
							n = n + 1'b1;
						end
						if (t == OffW'(13)) begin
							rec[n[1:0]] = '{F_TCP_FLAGS, {40'd0, data_byte}}; n = n + 1'b1;
						end
						if (t == OffW'(15)) begin
							rec[n[1:0]] = '{F_TCP_WIN, {32'd0, w16}}; n = n + 1'b1;
						end
						if (t == OffW'(17)) begin
							rec[n[1:0]] = '{F_TCP_CSUM, {32'd0, w16}}; n = n + 1'b1;
						end
						if ({5'd0, t} < seglen_q) begin
							if (t[0]) nxt_tcp = oc_add(nxt_tcp, w16);
							else if ({5'd0, t} == seglen_q - 16'd1)
								nxt_tcp = oc_add(nxt_tcp, {data_byte, 8'd0});
							if ({5'd0, t} == seglen_q - 16'd1 && nxt_pend[1]) begin
								rec[n[1:0]] = '{F_TCP_OK, {47'd0, nxt_tcp == 17'h0FFFF}};
								n = n + 1'b1;
								nxt_pend[1] = 1'b0;
							end
						end
					end
				end
			end
		end
		if (frame_end) begin
			if (nxt_pend[0] && n < 3'd4) begin rec[n[1:0]] = '{F_IP_OK, '0}; n = n + 1'b1; end
			if (nxt_pend[1] && n < 3'd4) begin rec[n[1:0]] = '{F_TCP_OK, '0}; n = n + 1'b1; end
			if (n < 3'd4) begin rec[n[1:0]] = '{F_END, '0}; n = n + 1'b1; end
			nxt_off = '0; nxt_shift = '0; nxt_ftype = '0; nxt_tlen = '0; nxt_seg = '0;
			nxt_hw = '0; nxt_proto = '0; nxt_ip = '0; nxt_tcp = '0; nxt_pend = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0; shift_q <= '0; ftype_q <= '0; tlen_q <= '0; seglen_q <= '0;
			hw_q <= '0; proto_q <= '0; ipsum_q <= '0; tcpsum_q <= '0; pend_q <= '0;
			cnt_q <= '0; rd_q <= '0;
		end else begin
			if (take) begin
				off_q <= nxt_off; shift_q <= nxt_shift; ftype_q <= nxt_ftype;
				tlen_q <= nxt_tlen; seglen_q <= nxt_seg; hw_q <= nxt_hw;
				proto_q <= nxt_proto; ipsum_q <= nxt_ip; tcpsum_q <= nxt_tcp;
				pend_q <= nxt_pend;
				cnt_q <= n; rd_q <= '0;
			end else if (valid_out && ready_out) begin
				cnt_q <= cnt_q - 1'b1;
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < 4; i++) buf_q[i] <= rec[i];
		end
	end

	assign valid_out = cnt_q != 3'd0;
	assign field_id = buf_q[rd_q].id;
	assign field_value = buf_q[rd_q].value;
	assign last_of_run = cnt_q == 3'd1;

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("record count overflow");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (cnt_q == 3'd0 || (cnt_q == 3'd1 && ready_out)))
		else $error("byte taken while records remain");
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && frame_end) |=> (off_q == '0 && pend_q == '0))
		else $error("frame state not cleared");
	a_off_bound: assert property (@(posedge clk) disable iff (!arst_n) off_q <= MaxOff)
		else $error("offset past frame limit");
endmodule
